FILE: rtl/ipfr_pkg.sv
// package of types, constants and the per-packet context for the reassembly classifier
package ipfr_pkg;

    // walk limit on consumed extension headers
    localparam int unsigned MAX_EXT_HEADERS = 11;

    // header size constants
    localparam logic [15:0] V4_MIN_LEN    = 16'd20;
    localparam logic [15:0] V6_BASE_LEN   = 16'd40;
    localparam logic [16:0] STRICT_LIMIT  = 17'd1272;
    localparam logic [15:0] FRAG_MASK     = 16'h3fff;
    localparam logic [16:0] EXT_MIN_LEN   = 17'd8;

    // ip versions
    localparam logic [3:0] IP_V4 = 4'd4;
    localparam logic [3:0] IP_V6 = 4'd6;

    // next header codes
    localparam logic [7:0] NH_HOP   = 8'd0;
    localparam logic [7:0] NH_TCP   = 8'd6;
    localparam logic [7:0] NH_ROUTE = 8'd43;
    localparam logic [7:0] NH_FRAG  = 8'd44;
    localparam logic [7:0] NH_DEST  = 8'd60;

    // verdict codes
    localparam logic [3:0] VERDICT_NOT_IP     = 4'd0;
    localparam logic [3:0] VERDICT_V4_FRAG    = 4'd1;
    localparam logic [3:0] VERDICT_V4_WHOLE   = 4'd2;
    localparam logic [3:0] VERDICT_V6_FRAG    = 4'd3;
    localparam logic [3:0] VERDICT_V6_OTHER   = 4'd4;
    localparam logic [3:0] VERDICT_SHORT      = 4'd5;
    localparam logic [3:0] VERDICT_EXT_TRUNC  = 4'd6;
    localparam logic [3:0] VERDICT_STRICT_REJ = 4'd7;
    localparam logic [3:0] VERDICT_WALK_LIMIT = 4'd8;

    // input item
    typedef struct packed {
        logic [7:0]  packet_byte;
        logic [15:0] buffer_len;
        logic        last_byte;
    } in_item_t;

    // result item
    typedef struct packed {
        logic       need_reassembly;
        logic [3:0] verdict;
    } out_item_t;

    // outcome of judging one header type
    typedef struct packed {
        logic       decide;
        logic [3:0] verdict;
    } judge_t;

    // per-packet walk context
    typedef struct packed {
        logic [15:0] byte_position;
        logic [3:0]  ip_version;
        logic [15:0] header_end;
        logic [7:0]  next_header_type;
        logic [3:0]  ext_header_count;
        logic [7:0]  offset_high_byte;
        logic        decided;
        logic [3:0]  verdict_hold;
    } ctx_t;

    localparam ctx_t CTX_RESET = '{
        byte_position:    16'd0,
        ip_version:       4'd0,
        header_end:       16'd40,
        next_header_type: 8'd0,
        ext_header_count: 4'd0,
        offset_high_byte: 8'd0,
        decided:          1'b0,
        verdict_hold:     4'd0
    };

endpackage

FILE: rtl/ipfr_step.sv
// next-context and verdict logic for one packet byte
module ipfr_step (
    input  ipfr_pkg::ctx_t     ctx,
    input  ipfr_pkg::in_item_t item,
    input  logic               strict,
    output ipfr_pkg::ctx_t     ctx_next,
    output ipfr_pkg::out_item_t result
);

    // judge the header type that starts at hend
    function automatic ipfr_pkg::judge_t judge(
        input logic [7:0]  t,
        input logic [15:0] hend,
        input logic [15:0] blen,
        input logic        strict_en
    );
        ipfr_pkg::judge_t j;
        logic [16:0]      reach;
        logic             past_buf;
        reach    = {1'b0, hend} + ipfr_pkg::EXT_MIN_LEN;
        past_buf = reach > {1'b0, blen};
        j.decide  = 1'b0;
        j.verdict = ipfr_pkg::VERDICT_V6_OTHER;
        if (t == ipfr_pkg::NH_TCP) begin
            j.decide = 1'b1;
        end else if (t == ipfr_pkg::NH_FRAG) begin
            j.decide = 1'b1;
            if (strict_en && (reach > ipfr_pkg::STRICT_LIMIT || past_buf))
                j.verdict = ipfr_pkg::VERDICT_STRICT_REJ;
            else
                j.verdict = ipfr_pkg::VERDICT_V6_FRAG;
        end else if (t == ipfr_pkg::NH_HOP || t == ipfr_pkg::NH_DEST ||
                     t == ipfr_pkg::NH_ROUTE) begin
            // wait for the header's own type and length unless it overruns
            if (past_buf) begin
                j.decide  = 1'b1;
                j.verdict = ipfr_pkg::VERDICT_EXT_TRUNC;
            end
        end else begin
            j.decide = 1'b1;
        end
        return j;
    endfunction

    logic [15:0]      pos;
    logic [7:0]       b;
    logic [15:0]      blen;
    logic [15:0]      frag_word;
    logic [11:0]      adv;
    logic [15:0]      hend_new;
    logic [3:0]       cnt_new;
    logic [3:0]       v;
    ipfr_pkg::judge_t j;
    ipfr_pkg::ctx_t   n;

    assign pos       = ctx.byte_position;
    assign b         = item.packet_byte;
    assign blen      = item.buffer_len;
    assign frag_word = {ctx.offset_high_byte, b};
    assign adv       = {1'b0, b, 3'b000} + 12'd8;
    assign hend_new  = ctx.header_end + {4'd0, adv};
    assign cnt_new   = ctx.ext_header_count + 4'd1;

    // one byte of the header walk
    always_comb begin
        n = ctx;
        j = '0;
        v = ipfr_pkg::VERDICT_SHORT;
        if (!ctx.decided) begin
            if (pos == 16'd0) begin
                n.ip_version = b[7:4];
                if (b[7:4] == ipfr_pkg::IP_V4) begin
                    if (blen < ipfr_pkg::V4_MIN_LEN) begin
                        n.decided      = 1'b1;
                        n.verdict_hold = ipfr_pkg::VERDICT_SHORT;
                    end
                end else if (b[7:4] == ipfr_pkg::IP_V6) begin
                    if (blen < ipfr_pkg::V6_BASE_LEN) begin
                        n.decided      = 1'b1;
                        n.verdict_hold = ipfr_pkg::VERDICT_SHORT;
                    end
                end else begin
                    n.decided      = 1'b1;
                    n.verdict_hold = ipfr_pkg::VERDICT_NOT_IP;
                end
            end else if (ctx.ip_version == ipfr_pkg::IP_V4) begin
                // flags and fragment offset word
                if (pos == 16'd6) begin
                    n.offset_high_byte = b;
                end else if (pos == 16'd7) begin
                    n.decided      = 1'b1;
                    n.verdict_hold = ((frag_word & ipfr_pkg::FRAG_MASK) != 16'd0) ?
                                     ipfr_pkg::VERDICT_V4_FRAG :
                                     ipfr_pkg::VERDICT_V4_WHOLE;
                end
            end else if (ctx.ip_version == ipfr_pkg::IP_V6) begin
                if (pos == 16'd6) begin
                    // base header next header field
                    n.next_header_type = b;
                    j = judge(b, ctx.header_end, blen, strict);
                    if (j.decide) begin
                        n.decided      = 1'b1;
                        n.verdict_hold = j.verdict;
                    end
                end else if (pos > 16'd6) begin
                    if (pos == ctx.header_end) begin
                        n.next_header_type = b;
                    end else if ({1'b0, pos} == {1'b0, ctx.header_end} + 17'd1) begin
                        // extension header length byte
                        if ({4'd0, adv} > blen) begin
                            n.decided      = 1'b1;
                            n.verdict_hold = ipfr_pkg::VERDICT_EXT_TRUNC;
                        end else begin
                            n.header_end       = hend_new;
                            n.ext_header_count = cnt_new;
                            if (cnt_new >= 4'(ipfr_pkg::MAX_EXT_HEADERS)) begin
                                n.decided      = 1'b1;
                                n.verdict_hold = ipfr_pkg::VERDICT_WALK_LIMIT;
                            end else begin
                                j = judge(ctx.next_header_type, hend_new, blen, strict);
                                if (j.decide) begin
                                    n.decided      = 1'b1;
                                    n.verdict_hold = j.verdict;
                                end
                            end
                        end
                    end
                end
            end
        end

        // verdict on the last byte, then start a new packet
        if (n.decided)
            v = n.verdict_hold;
        result.verdict         = v;
        result.need_reassembly = (v == ipfr_pkg::VERDICT_V4_FRAG ||
                                  v == ipfr_pkg::VERDICT_V6_FRAG);
        if (item.last_byte) begin
            ctx_next = ipfr_pkg::CTX_RESET;
        end else begin
            ctx_next = n;
            if (ctx.byte_position != 16'hffff)
                ctx_next.byte_position = ctx.byte_position + 16'd1;
        end
    end

endmodule

FILE: rtl/ip_fragment_reassembly_classifier.sv
// top level of the ip fragment reassembly classifier
//
// Bytes of a packet's first buffer enter on the s_ channel, one per item, in
// order from offset zero; each item also carries the buffer length and a flag
// on the final byte. On that final byte one verdict item leaves on the m_
// channel: whether the packet needs reassembly and a verdict code. Bytes that
// are not last give no result.
// Throughput is one byte per cycle while no last byte is held back by a waiting
// verdict. An accepted item is held in an input register and worked on from
// there; its verdict is then written to the result register and shows on
// m_valid. The context and result registers are fed by a single pass of
// compares and adds from the input register.
// The strict fragment check bit is written through cfg_wr_en/cfg_wr_data;
// the user must do so only while the block is idle; the block does not enforce it.
// Reset (aresetn low, synchronous) empties both registers, clears the
// strict bit and starts a new packet at offset zero.
// When the receiver stalls, the verdict waits in the result register; bytes
// that are not last keep flowing, and a further last byte waits in the input
// register until the verdict is taken.
module ip_fragment_reassembly_classifier (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  ipfr_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output ipfr_pkg::out_item_t m_item
);

    logic                in_valid_reg, in_valid_next;
    ipfr_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg, out_valid_next;
    ipfr_pkg::out_item_t out_item_reg;
    ipfr_pkg::ctx_t      ctx_reg, ctx_next;
    logic                strict_reg;
    ipfr_pkg::out_item_t step_result;
    logic                advance;

    // process the held item unless it is a last byte blocked by a waiting verdict
    assign advance = in_valid_reg && (!in_item_reg.last_byte || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    // per-byte walk logic
    ipfr_step u_step (
        .ctx      (ctx_reg),
        .item     (in_item_reg),
        .strict   (strict_reg),
        .ctx_next (ctx_next),
        .result   (step_result)
    );

    // valid flags
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (advance && in_item_reg.last_byte)
            out_valid_next = 1'b1;
        else if (m_ready)
            out_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctx_reg       <= ipfr_pkg::CTX_RESET;
            strict_reg    <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                ctx_reg <= ctx_next;
            if (cfg_wr_en)
                strict_reg <= cfg_wr_data;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready)
            in_item_reg <= s_item;
        if (advance && in_item_reg.last_byte)
            out_item_reg <= step_result;
    end

endmodule
